@@ sv/tapd_pkg.sv @@
package tapd_pkg;

    localparam int LANES    = 4;
    localparam int SAMPLE_W = 12;
    localparam int DIM_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_TILE_WIDTH  = 1024;
    localparam int DEF_MAX_TILE_HEIGHT = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd2;

    // position info of one item, shared by all lanes
    typedef struct packed {
        logic             raw;   // first item of the tile
        logic             row0;  // first slice row
        logic             col0;  // first column
        logic             last;  // final item of the tile
        logic [LANES-1:0] act;   // slice active in this row
    } t_pos_ctl;

endpackage

@@ sv/tapd_pos.sv @@
module tapd_pos #(
    parameter int MAX_TILE_WIDTH  = tapd_pkg::DEF_MAX_TILE_WIDTH,
    parameter int MAX_TILE_HEIGHT = tapd_pkg::DEF_MAX_TILE_HEIGHT,
    parameter int CW              = $clog2(MAX_TILE_WIDTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tapd_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [tapd_pkg::DIM_W-1:0]          i_cfg_wdata,
    input  logic                                i_accept,
    output logic [CW-1:0]                       o_col,
    output tapd_pkg::t_pos_ctl                  o_ctl,
    output logic                                o_decode
);

    localparam int HW    = $clog2(MAX_TILE_HEIGHT + 1);
    localparam int SROWS = (MAX_TILE_HEIGHT + 3) / 4;
    localparam int RW    = $clog2(SROWS + 1);

    logic [tapd_pkg::DIM_W-1:0] r_width, r_height;
    logic                       r_decode;
    logic [CW-1:0]              r_col, n_col;
    logic [RW-1:0]              r_row, n_row;

    logic [CW-1:0] w;
    logic [HW-1:0] h;
    logic [RW-1:0] srows;
    logic [1:0]    rem;
    logic          col_end, row_end;

    // clamp geometry: zero acts as one, saturate at the maximum
    always_comb begin
        if (r_width == '0) begin
            w = CW'(1);
        end else if (32'(r_width) > 32'(MAX_TILE_WIDTH)) begin
            w = CW'(MAX_TILE_WIDTH);
        end else begin
            w = CW'(r_width);
        end
        if (r_height == '0) begin
            h = HW'(1);
        end else if (32'(r_height) > 32'(MAX_TILE_HEIGHT)) begin
            h = HW'(MAX_TILE_HEIGHT);
        end else begin
            h = HW'(r_height);
        end
    end

    assign srows   = RW'((32'(h) + 32'd3) >> 2);
    assign rem     = 2'(h);
    assign col_end = (r_col == w - CW'(1));
    assign row_end = (r_row == srows - RW'(1));

    always_comb begin
        o_ctl.raw  = (r_col == '0) && (r_row == '0);
        o_ctl.row0 = (r_row == '0);
        o_ctl.col0 = (r_col == '0);
        o_ctl.last = col_end && row_end;
        for (int k = 0; k < tapd_pkg::LANES; k++) begin
            o_ctl.act[k] = (32'(r_row) + 32'd1 < 32'(srows)) || (rem == 2'd0)
                           || (32'(rem) > k);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        // geometry write restarts the tile
        if (i_cfg_we && (i_cfg_addr == tapd_pkg::CFG_TILE_WIDTH ||
                         i_cfg_addr == tapd_pkg::CFG_TILE_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tapd_pkg::DIM_W'(1);
            r_height <= tapd_pkg::DIM_W'(1);
            r_decode <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    tapd_pkg::CFG_TILE_WIDTH:  r_width  <= i_cfg_wdata;
                    tapd_pkg::CFG_TILE_HEIGHT: r_height <= i_cfg_wdata;
                    tapd_pkg::CFG_DECODE_MODE: r_decode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_col    = r_col;
    assign o_decode = r_decode;

endmodule

@@ sv/tapd_lane.sv @@
module tapd_lane #(
    parameter int LANE           = 0,
    parameter int MAX_TILE_WIDTH = tapd_pkg::DEF_MAX_TILE_WIDTH,
    parameter int CW             = $clog2(MAX_TILE_WIDTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,  // item enters the predict stage
    input  logic                          i_adv,     // predict stage moves to output
    input  logic [CW-1:0]                 i_col,
    input  tapd_pkg::t_pos_ctl            i_ctl,
    input  logic [tapd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_decode,
    output logic [tapd_pkg::SAMPLE_W-1:0] o_result
);

    localparam int AW = (MAX_TILE_WIDTH > 1) ? $clog2(MAX_TILE_WIDTH) : 1;
    localparam int PW = tapd_pkg::SAMPLE_W;

    logic [PW-1:0] r_mem [MAX_TILE_WIDTH];

    logic [PW-1:0]       r_sample, r_top, r_fwd_pix, r_left;
    tapd_pkg::t_pos_ctl  r_ctl;
    logic [AW-1:0]       r_addr;
    logic                r_fwd;

    logic [PW-1:0] top, pred, pix, res;
    logic [PW:0]   sum;
    logic          act;

    assign act = r_ctl.act[LANE];

    // row above: bypass the write made in the same cycle as the read
    assign top = r_fwd ? r_fwd_pix : r_top;
    assign sum = {1'b0, r_left} + {1'b0, top};

    always_comb begin
        if (r_ctl.row0) begin
            pred = r_left;
        end else if (r_ctl.col0) begin
            pred = top;
        end else begin
            pred = sum[PW:1];
        end
        if (r_ctl.raw) begin
            pix = r_sample;
            res = r_sample;
        end else if (i_decode) begin
            pix = r_sample + pred;
            res = pix;
        end else begin
            pix = r_sample;
            res = r_sample - pred;
        end
    end

    assign o_result = act ? res : '0;

    always_ff @(posedge i_clk) begin
        if (i_adv && act) begin
            r_mem[r_addr] <= pix;
        end
        if (i_accept) begin
            r_top <= r_mem[i_col[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample  <= i_sample;
            r_ctl     <= i_ctl;
            r_addr    <= i_col[AW-1:0];
            r_fwd     <= i_adv && act && (r_addr == i_col[AW-1:0]);
            r_fwd_pix <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_adv && act) begin
            r_left <= pix;
        end
    end

endmodule

@@ sv/tile_average_predictor_dpcm.sv @@
// Tile average-predictor DPCM coder, 12-bit pixels, four slice lanes.
//
// Input stream (s_axis): one item per column position, carrying one sample
// for each of the four horizontal slices of the tile. Items run in row
// order through the slice rows. Output stream (m_axis): one item per
// input item with the four lane results, the active-lane mask, a raw-start
// flag (first item of a tile) and tlast on the final item of the tile.
// Config port: i_cfg_we with i_cfg_addr 0 = tile_width, 1 = tile_height,
// 2 = decode_mode; written only while no item is in flight. A geometry
// write restarts the tile.
// Pipeline: at the input accept edge the row buffer is read and the item
// enters the predict stage; the predict result is registered into the
// output register when the predict stage advances.
// Throughput: one item per cycle while the receiver takes the output; the
// row buffer of each lane is read and written at most once per cycle.
// Reset clears position, geometry (1x1), mode and the left pixels; the
// row buffers are not cleared and are only read after being written.
// When the receiver stalls, the output register holds, the predict stage
// fills, and s_axis_tready drops until the output item is taken.
module tile_average_predictor_dpcm #(
    parameter int MAX_TILE_WIDTH  = tapd_pkg::DEF_MAX_TILE_WIDTH,
    parameter int MAX_TILE_HEIGHT = tapd_pkg::DEF_MAX_TILE_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tapd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [tapd_pkg::DIM_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // lane0_sample, lane1_sample, lane2_sample, lane3_sample
    input  logic [47:0]                        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // lane0_result, lane1_result, lane2_result, lane3_result
    output logic [47:0]                        m_axis_tdata,
    // lane_valid[3:0], is_raw_start
    output logic [4:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int CW = $clog2(MAX_TILE_WIDTH + 1);
    localparam int L  = tapd_pkg::LANES;
    localparam int PW = tapd_pkg::SAMPLE_W;

    logic               accept, adv;
    logic [CW-1:0]      col;
    tapd_pkg::t_pos_ctl ctl;
    logic               decode;

    // predict stage control
    logic               r_s1_valid;
    logic               r_s1_raw, r_s1_last;
    logic [L-1:0]       r_s1_act;

    // output register
    logic               r_o_valid;
    logic [L*PW-1:0]    r_o_data;
    logic [L-1:0]       r_o_lv;
    logic               r_o_raw, r_o_last;

    logic [L*PW-1:0]    lane_res;

    assign adv           = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tapd_pos #(
        .MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
        .MAX_TILE_HEIGHT (MAX_TILE_HEIGHT),
        .CW              (CW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .o_col       (col),
        .o_ctl       (ctl),
        .o_decode    (decode)
    );

    for (genvar k = 0; k < L; k++) begin : g_lane
        tapd_lane #(
            .LANE           (k),
            .MAX_TILE_WIDTH (MAX_TILE_WIDTH),
            .CW             (CW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_adv    (adv),
            .i_col    (col),
            .i_ctl    (ctl),
            .i_sample (s_axis_tdata[k*PW +: PW]),
            .i_decode (decode),
            .o_result (lane_res[k*PW +: PW])
        );
    end

    // predict stage valid and item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_raw  <= ctl.raw;
            r_s1_last <= ctl.last;
            r_s1_act  <= ctl.act;
        end
    end

    // merge: lane results and item flags into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_data <= lane_res;
            r_o_lv   <= r_s1_act;
            r_o_raw  <= r_s1_raw;
            r_o_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = {r_o_raw, r_o_lv};
    assign m_axis_tlast  = r_o_last;

    // an accepted item always lands in the predict stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost before predict stage");

    // a stalled predict stage keeps its item
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> r_s1_valid)
        else $error("predict stage dropped a stalled item");

    // slice 0 is active in every slice row
    a_lane0_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_lv[0])
        else $error("slice 0 marked inactive");

endmodule
